// ===== rtl/mls_pkg.sv =====
`default_nettype none

package mls_pkg;

	// Integer width and store sizes.
	localparam int NUM_W       = 12;
	localparam int MAX_N       = 1 << NUM_W;
	localparam int PRIME_SLOTS = 1024;
	localparam int PIDX_W      = $clog2(PRIME_SLOTS);
	localparam int CNT_W       = PIDX_W + 1;
	localparam int PROD_W      = 2 * NUM_W;

	// Mobius codes as kept in the store; the bit patterns equal the 2-bit
	// two's complement values, so the store code is the reported value.
	localparam int MU_W = 2;
	localparam logic [MU_W-1:0] MU_ZERO = 2'b00;
	localparam logic [MU_W-1:0] MU_POS  = 2'b01;
	localparam logic [MU_W-1:0] MU_NEG  = 2'b11;

	// Remainder unit: quotient bits retired per cycle.
	localparam int DIV_STEP   = 2;
	localparam int DIV_CYCLES = NUM_W / DIV_STEP;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

	typedef struct packed {
		logic clr_step;   // clear one composite mark, advance the sweep
		logic start_one;  // start a new run at integer 1
		logic adv;        // take the next integer and sieve it
		logic rep;        // repeat the current integer
		logic chk;        // look at the marks of the integer, record a prime
		logic p_rd;       // read the prime at the walk index
		logic p_mul;      // form p*i and start the remainder unit
		logic p_wr;       // mark p*i and write its Mobius value
		logic out_load;   // move the finished result to the output register
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic cur_zero;
		logic cur_lt_lim;
		logic clean;
		logic adv;
		logic j_end;
		logic prod_gt;
		logic div_busy;
		logic rem_zero;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/mls_ram.sv =====
`default_nettype none

module mls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mls_div.sv =====
`default_nettype none

module mls_div
	import mls_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire  [NUM_W-1:0] dividend,
	input  wire  [NUM_W-1:0] divisor,
	output logic             busy,
	output logic             rem_zero
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     dvd_q;
	logic [NUM_W-1:0]     dvs_q;
	logic [NUM_W-1:0]     rem_q;
	logic [NUM_W-1:0]     rem_nxt;

	// One restoring step: shift in a dividend bit, subtract if it fits.
	function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] r,
			input logic b, input logic [NUM_W-1:0] d);
		logic [NUM_W:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[NUM_W-1:0];
	endfunction

	always_comb begin
		rem_nxt = rem_q;
		for (int k = 0; k < DIV_STEP; k++) begin
			rem_nxt = div_step(rem_nxt, dvd_q[NUM_W-1-k], dvs_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_CYCLES);
		end else if (busy) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			dvd_q <= dvd_q << DIV_STEP;
			rem_q <= rem_nxt;
		end
	end

	assign busy     = (cnt_q != '0);
	assign rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

// ===== rtl/mls_ctrl.sv =====
`default_nettype none

module mls_ctrl
	import mls_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	input  wire   restart,
	output logic  in_stall,
	input  sts_t  sts,
	output cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_INIT  = 11'b000_0000_0001,
		S_IDLE  = 11'b000_0000_0010,
		S_CLEAR = 11'b000_0000_0100,
		S_ONE   = 11'b000_0000_1000,
		S_READ  = 11'b000_0001_0000,
		S_CHK   = 11'b000_0010_0000,
		S_PREAD = 11'b000_0100_0000,
		S_PMUL  = 11'b000_1000_0000,
		S_PCMP  = 11'b001_0000_0000,
		S_DWAIT = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					if (restart || sts.cur_zero) begin
						state_nxt = sts.clean ? S_ONE : S_CLEAR;
					end else if (sts.cur_lt_lim) begin
						cmd.adv   = 1'b1;
						state_nxt = S_READ;
					end else begin
						cmd.rep   = 1'b1;
						state_nxt = S_READ;
					end
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_ONE;
				end
			end
			S_ONE: begin
				cmd.start_one = 1'b1;
				state_nxt     = S_DONE;
			end
			S_READ: begin
				state_nxt = S_CHK;
			end
			S_CHK: begin
				cmd.chk   = 1'b1;
				state_nxt = sts.adv ? S_PREAD : S_DONE;
			end
			S_PREAD: begin
				if (sts.j_end) begin
					state_nxt = S_DONE;
				end else begin
					cmd.p_rd  = 1'b1;
					state_nxt = S_PMUL;
				end
			end
			S_PMUL: begin
				cmd.p_mul = 1'b1;
				state_nxt = S_PCMP;
			end
			S_PCMP: begin
				state_nxt = sts.prod_gt ? S_DONE : S_DWAIT;
			end
			S_DWAIT: begin
				if (!sts.div_busy) begin
					cmd.p_wr  = 1'b1;
					state_nxt = sts.rem_zero ? S_DONE : S_PREAD;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/mls_dp.sv =====
`default_nettype none

module mls_dp
	import mls_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  wire  [NUM_W-1:0]        cfg_wdata,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [NUM_W-1:0]        number,
	output logic signed [MU_W-1:0]  mobius,
	output logic                    is_prime,
	output logic                    at_limit
);

	logic [NUM_W-1:0]  lim_q;
	logic [NUM_W-1:0]  eff_lim;
	logic [NUM_W-1:0]  cur_q;
	logic              adv_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  j_q;
	logic [NUM_W-1:0]  clr_q;
	logic              clean_q;
	logic [PROD_W-1:0] prod_q;
	logic [MU_W-1:0]   mui_q;
	logic [NUM_W-1:0]  res_num_q;
	logic [MU_W-1:0]   res_mu_q;
	logic              res_prime_q;
	logic              out_valid_q;
	logic [NUM_W-1:0]  number_q;
	logic [MU_W-1:0]   mobius_q;
	logic              is_prime_q;
	logic              at_limit_q;

	logic              mark_rdata;
	logic [MU_W-1:0]   mu_rdata;
	logic [NUM_W-1:0]  p_rdata;
	logic              prime;
	logic              new_prime;
	logic              list_room;
	logic              mark_we;
	logic [NUM_W-1:0]  mark_waddr;
	logic              mu_we;
	logic [NUM_W-1:0]  mu_waddr;
	logic [MU_W-1:0]   mu_wdata;
	logic              list_we;
	logic              div_busy;
	logic              rem_zero;
	logic [NUM_W-1:0]  prod_lo;

	// A limit of zero behaves as one; the field cannot exceed MAX_N-1.
	assign eff_lim = (lim_q == '0) ? NUM_W'(1) : lim_q;

	assign prod_lo   = prod_q[NUM_W-1:0];
	assign prime     = (cur_q[NUM_W-1:1] != '0) && !mark_rdata;
	assign new_prime = cmd.chk && adv_q && prime;
	assign list_room = (count_q < CNT_W'(PRIME_SLOTS));

	assign mark_we    = cmd.clr_step || cmd.p_wr;
	assign mark_waddr = cmd.clr_step ? clr_q : prod_lo;
	assign mu_we      = new_prime || cmd.p_wr;
	assign mu_waddr   = cmd.chk ? cur_q : prod_lo;
	assign mu_wdata   = cmd.chk ? MU_NEG :
		(rem_zero ? MU_ZERO : MU_W'(~mui_q + MU_W'(1)));
	assign list_we    = new_prime && list_room;

	mls_ram #(
		.WIDTH (1),
		.DEPTH (MAX_N)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (!cmd.clr_step),
		.re    (1'b1),
		.raddr (cur_q),
		.rdata (mark_rdata)
	);

	mls_ram #(
		.WIDTH (MU_W),
		.DEPTH (MAX_N)
	) u_mu_ram (
		.clk   (clk),
		.we    (mu_we),
		.waddr (mu_waddr),
		.wdata (mu_wdata),
		.re    (1'b1),
		.raddr (cur_q),
		.rdata (mu_rdata)
	);

	mls_ram #(
		.WIDTH (NUM_W),
		.DEPTH (PRIME_SLOTS)
	) u_prime_ram (
		.clk   (clk),
		.we    (list_we),
		.waddr (count_q[PIDX_W-1:0]),
		.wdata (cur_q),
		.re    (cmd.p_rd),
		.raddr (j_q[PIDX_W-1:0]),
		.rdata (p_rdata)
	);

	mls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.p_mul),
		.dividend (cur_q),
		.divisor  (p_rdata),
		.busy     (div_busy),
		.rem_zero (rem_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q       <= '1;
			cur_q       <= '0;
			adv_q       <= 1'b0;
			count_q     <= '0;
			j_q         <= '0;
			clr_q       <= '0;
			clean_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				lim_q <= cfg_wdata;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + NUM_W'(1);
				if (clr_q == '1) begin
					clean_q <= 1'b1;
				end
			end
			if (cmd.start_one) begin
				cur_q   <= NUM_W'(1);
				count_q <= '0;
			end
			if (cmd.adv) begin
				cur_q <= cur_q + NUM_W'(1);
				adv_q <= 1'b1;
			end
			if (cmd.rep) begin
				adv_q <= 1'b0;
			end
			if (cmd.chk) begin
				j_q <= '0;
			end
			if (list_we) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.p_wr) begin
				j_q     <= j_q + CNT_W'(1);
				clean_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_one) begin
			res_num_q   <= NUM_W'(1);
			res_mu_q    <= MU_POS;
			res_prime_q <= 1'b0;
		end
		if (cmd.chk) begin
			res_num_q   <= cur_q;
			res_prime_q <= prime;
			if (cur_q == NUM_W'(1)) begin
				res_mu_q <= MU_POS;
			end else if (new_prime) begin
				res_mu_q <= MU_NEG;
			end else begin
				res_mu_q <= mu_rdata;
			end
			mui_q <= new_prime ? MU_NEG : mu_rdata;
		end
		if (cmd.p_mul) begin
			prod_q <= PROD_W'(p_rdata) * PROD_W'(cur_q);
		end
		if (cmd.out_load) begin
			number_q   <= res_num_q;
			mobius_q   <= res_mu_q;
			is_prime_q <= res_prime_q;
			at_limit_q <= (res_num_q == eff_lim);
		end
	end

	always_comb begin
		sts            = '0;
		sts.clr_last   = (clr_q == '1);
		sts.cur_zero   = (cur_q == '0);
		sts.cur_lt_lim = (cur_q < eff_lim);
		sts.clean      = clean_q;
		sts.adv        = adv_q;
		sts.j_end      = (j_q == count_q);
		sts.prod_gt    = (prod_q > PROD_W'(eff_lim));
		sts.div_busy   = div_busy;
		sts.rem_zero   = rem_zero;
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign number    = number_q;
	assign mobius    = $signed(mobius_q);
	assign is_prime  = is_prime_q;
	assign at_limit  = at_limit_q;

endmodule

`default_nettype wire

// ===== rtl/mobius_linear_sieve.sv =====
// Linear sieve that reports, item by item, the Mobius value and primality of
// the integers 1, 2, 3, ... up to the limit register.
// Input channel (in_valid, in_stall, restart): restart=1 starts over at 1,
// restart=0 advances to the next integer; past the limit the last integer
// is reported again. One item is worked at a time; in_stall is high while
// an item is in progress.
// Output channel (out_valid, out_stall): one result item per input item,
// held in an output register. While the receiver stalls, the next input
// item is still taken and worked; its result waits until the register frees.
// Steps: an advance reads the integer's marks, then, for every stored prime
// it walks, does one prime-list read, a 12x12 multiply, and a remainder
// unit run retiring 2 bits a cycle. A repeat skips the prime walk.
// A restart clears the 4096 composite marks one per cycle unless no mark
// has been set since the last sweep. After reset the block runs the same
// sweep before it takes the first item; the limit resets to 4095 and may
// be written at any time by cfg_we/cfg_wdata, though only between items
// for consistent results.
`default_nettype none

module mobius_linear_sieve
	import mls_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  wire  [NUM_W-1:0]        cfg_wdata,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire                     restart,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [NUM_W-1:0]        number,
	output logic signed [MU_W-1:0]  mobius,
	output logic                    is_prime,
	output logic                    at_limit
);

	cmd_t cmd;
	sts_t sts;

	mls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.restart  (restart),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mls_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.number    (number),
		.mobius    (mobius),
		.is_prime  (is_prime),
		.at_limit  (at_limit)
	);

	// Only one item is in progress at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in progress");

	// The Mobius value is never the unused code.
	a_mu_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mobius != 2'sb10)
		else $error("mobius result out of range");

	// A prime always has Mobius value minus one.
	a_prime_mu: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_prime |-> mobius == 2'sb11)
		else $error("prime reported with wrong mobius value");

	// Integer one is not prime and has Mobius value one.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && number == NUM_W'(1) |-> !is_prime && mobius == 2'sb01)
		else $error("wrong result for integer one");

endmodule

`default_nettype wire
